FILE: design/scfl_pkg.sv
// ============================================================================
// scfl_pkg
// Shared constants, types and the size-to-class lookup for the size class
// free list allocator.
// ============================================================================
`default_nettype none

package scfl_pkg;

    // Pool geometry
    localparam int SLOTS_PER_CLASS = 512;
    localparam int NUM_CLASSES     = 4;

    // Payload widths fixed by the interface
    localparam int TYPE_W = 1;
    localparam int SIZE_W = 16;
    localparam int CLS_W  = 2;
    localparam int SLOT_W = 9;
    localparam int STAT_W = 2;

    // Derived storage widths
    localparam int POS_W     = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int CNT_W     = $clog2(SLOTS_PER_CLASS + 1);
    localparam int ADDR_W    = CLS_W + POS_W;
    localparam int RAM_DEPTH = NUM_CLASSES * (1 << POS_W);

    // Largest size that maps to a class
    localparam logic [SIZE_W-1:0] MAX_SIZE = 16'd2048;

    // Packed two-bit class per 256-byte step, zero padded to 16 entries
    localparam logic [31:0] CLASS_TABLE = 32'h0003_FFA4;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Stack memory access, one read or one write per cycle
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] wdata;
    } t_ram_req;

    // Class from size bits [11:8]
    function automatic logic [CLS_W-1:0] class_of_step(input logic [3:0] step);
        logic [4:0] bit_idx;
        bit_idx = {step, 1'b0};
        return CLASS_TABLE[bit_idx +: CLS_W];
    endfunction

endpackage

`default_nettype wire

FILE: design/scfl_if.sv
// ============================================================================
// scfl_req_if / scfl_rsp_if
// Valid/ready channels for allocator requests and results.
// ============================================================================
`default_nettype none

interface scfl_req_if;
    logic                        valid;
    logic                        ready;
    logic [scfl_pkg::TYPE_W-1:0] req_type;
    logic [scfl_pkg::SIZE_W-1:0] req_size;
    logic [scfl_pkg::CLS_W-1:0]  free_class;
    logic [scfl_pkg::SLOT_W-1:0] free_slot;

    modport source (output valid, req_type, req_size, free_class, free_slot,
                    input ready);
    modport sink   (input valid, req_type, req_size, free_class, free_slot,
                    output ready);
endinterface

interface scfl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [scfl_pkg::CLS_W-1:0]  granted_class;
    logic [scfl_pkg::SLOT_W-1:0] granted_slot;
    logic [scfl_pkg::STAT_W-1:0] status;

    modport source (output valid, granted_class, granted_slot, status,
                    input ready);
    modport sink   (input valid, granted_class, granted_slot, status,
                    output ready);
endinterface

`default_nettype wire

FILE: design/scfl_stack_ram.sv
// ============================================================================
// scfl_stack_ram
// Single-port free stack storage for all classes, registered read data.
// ============================================================================
`default_nettype none

module scfl_stack_ram (
    input  wire logic                        i_clk,
    input  wire scfl_pkg::t_ram_req          i_req,
    output logic [scfl_pkg::SLOT_W-1:0]      o_rdata
);
    import scfl_pkg::*;

    logic [SLOT_W-1:0] r_mem [RAM_DEPTH];
    logic [SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/size_class_free_list_allocator_top.sv
// ============================================================================
// size_class_free_list_allocator_top
// Path: a request passes the stage 1 register, then the output register.
// Throughput: one request per cycle unless stalled; bound by the single RAM port.
// Reset: synchronous, active low; every class starts full with slot 0 on top.
// No clearing pass: a per-class low-water mark serves never-written entries.
// ============================================================================
`default_nettype none

// Buffer allocator with four size classes (256, 512, 1024, 2048 bytes).
//
// Stage 0 (request transfer):
//   - Map the size to a class, or take the free class for a free request.
//   - Check the class fill count held in flops and update it right away, so
//     the next request in the following cycle sees the new count.
//   - Pop: read the stack memory at the new top position.
//   - Push: write the freed slot at the old count position.
// Stage 1:
//   - Memory read data arrives. A position below the class's low-water
//     mark was never written since reset and reads as its reset slot,
//     which is computed in stage 0 and carried along.
// Output register:
//   - Holds the result until the sink takes it. Stage 1 advances into it
//     when it is empty or draining, so one request per cycle flows through.
//
// Only one memory access happens per cycle, and a pop right after a push
// to the same class reads the entry the push already wrote, so no
// forwarding is needed.

module size_class_free_list_allocator_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    scfl_req_if.sink   i_req,
    scfl_rsp_if.source o_rsp
);
    import scfl_pkg::*;

    // ------------------------------------------------------------------
    // Per-class state in flops
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count [NUM_CLASSES];
    logic [CNT_W-1:0] r_low   [NUM_CLASSES];

    // Stage 1 and output registers
    logic              r_s1_valid;
    logic              r_s1_grant;
    logic              r_s1_from_mem;
    logic [CLS_W-1:0]  r_s1_class;
    logic [SLOT_W-1:0] r_s1_init_slot;
    logic [STAT_W-1:0] r_s1_status;

    logic              r_o_valid;
    logic [CLS_W-1:0]  r_o_class;
    logic [SLOT_W-1:0] r_o_slot;
    logic [STAT_W-1:0] r_o_status;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s1_move;
    logic req_xfer;

    assign s1_move     = !r_o_valid || o_rsp.ready;
    assign i_req.ready = i_rst_n && (!r_s1_valid || s1_move);
    assign req_xfer    = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // Stage 0 decode
    // ------------------------------------------------------------------
    logic              is_alloc;
    logic              too_large;
    logic [CLS_W-1:0]  cls;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  low;
    logic [CNT_W-1:0]  cnt_dec;
    logic              pop_ok;
    logic              push_ok;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pop_pos;
    logic [POS_W-1:0]  init_pos;
    logic              from_mem;
    t_ram_req          ram_req;
    logic [SLOT_W-1:0] ram_rdata;

    always_comb begin
        is_alloc  = (i_req.req_type == REQ_ALLOC);
        too_large = (i_req.req_size > MAX_SIZE);
        cls       = is_alloc ? class_of_step(i_req.req_size[11:8]) : i_req.free_class;
        cnt       = r_count[cls];
        low       = r_low[cls];
        cnt_dec   = cnt - CNT_W'(1);

        pop_ok  = is_alloc && !too_large && (cnt != '0);
        push_ok = !is_alloc && (cnt != CNT_W'(SLOTS_PER_CLASS));

        if (is_alloc) begin
            if (too_large) begin
                status = ST_TOO_LARGE;
            end else if (cnt == '0) begin
                status = ST_EXHAUSTED;
            end else begin
                status = ST_OK;
            end
        end else begin
            status = push_ok ? ST_OK : ST_FULL;
        end

        // New top position on a pop; reset content is SLOTS-1-position
        pop_pos  = cnt_dec[POS_W-1:0];
        init_pos = POS_W'(SLOTS_PER_CLASS - 1) - pop_pos;
        from_mem = (cnt_dec >= low);

        ram_req.we    = req_xfer && push_ok;
        ram_req.re    = req_xfer && pop_ok;
        ram_req.addr  = {cls, (is_alloc ? pop_pos : cnt[POS_W-1:0])};
        ram_req.wdata = i_req.free_slot;
    end

    // ------------------------------------------------------------------
    // Fill counts and low-water marks
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= CNT_W'(SLOTS_PER_CLASS);
                r_low[c]   <= CNT_W'(SLOTS_PER_CLASS);
            end
        end else if (req_xfer) begin
            if (pop_ok) begin
                r_count[cls] <= cnt_dec;
                // Track the deepest point reached; below it the stack is untouched
                if (!from_mem) begin
                    r_low[cls] <= cnt_dec;
                end
            end else if (push_ok) begin
                r_count[cls] <= cnt + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stack memory
    // ------------------------------------------------------------------
    scfl_stack_ram u_stack_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: wait for read data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_s1_grant     <= pop_ok;
            r_s1_from_mem  <= from_mem;
            r_s1_class     <= pop_ok ? cls : '0;
            r_s1_init_slot <= SLOT_W'(init_pos);
            r_s1_status    <= status;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_o_class  <= r_s1_class;
            r_o_status <= r_s1_status;
            if (!r_s1_grant) begin
                r_o_slot <= '0;
            end else if (r_s1_from_mem) begin
                r_o_slot <= ram_rdata;
            end else begin
                r_o_slot <= r_s1_init_slot;
            end
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.granted_class = r_o_class;
    assign o_rsp.granted_slot  = r_o_slot;
    assign o_rsp.status        = r_o_status;

endmodule

`default_nettype wire

FILE: design/scfl_checker.sv
// ============================================================================
// scfl_checker
// Port-level checks for the allocator, bound to the top level.
// ============================================================================
`default_nettype none

module scfl_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic [scfl_pkg::CLS_W-1:0]  i_rsp_class,
    input wire logic [scfl_pkg::SLOT_W-1:0] i_rsp_slot,
    input wire logic [scfl_pkg::STAT_W-1:0] i_rsp_status
);
    import scfl_pkg::*;

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_class) && $stable(i_rsp_slot)
            && $stable(i_rsp_status))
        else $error("result changed while stalled");

    // Failed requests grant nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_class == '0 && i_rsp_slot == '0)
        else $error("failed request carries a grant");

    // Request side only stalls behind a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid && !i_rsp_ready)
        else $error("request stalled without output backpressure");

    // A transfer followed by a free output path yields a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready ##1 (!i_rsp_valid || i_rsp_ready) |=> i_rsp_valid)
        else $error("result missing after request transfer");

endmodule

bind size_class_free_list_allocator_top scfl_checker u_scfl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_class  (o_rsp.granted_class),
    .i_rsp_slot   (o_rsp.granted_slot),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
